>>> hw/rtl/bfmm_pkg.sv
// bfmm_pkg: transaction types, codes and bf16/fp32 helpers for the bf16 matmul block
// no dependencies; imported by every module of the block except bfmm_store
package bfmm_pkg;

    localparam int CFG_DW = 7;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_LAYOUT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INNER  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BATCH  = 2'd2;

    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_EMIT = 2'd2;

    localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;
    localparam logic [31:0] F32_QUIET   = 32'h0040_0000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [15:0] element;
    } t_in;

    typedef struct packed {
        logic [15:0] out_value;
        logic [5:0]  out_col;
        logic        row_last;
    } t_out;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_ctl;

    function automatic logic [15:0] f32_to_bf16(input logic [31:0] b);
        logic [31:0] t;
        t = b + 32'h0000_7FFF + {31'b0, b[16]};
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
            return b[31:16] | 16'h0040;
        end
        return t[31:16];
    endfunction

endpackage

>>> hw/rtl/bfmm_store.sv
// bfmm_store: element memories for operands a and b, one write and one read port each
// depends on nothing; read data registered
module bfmm_store #(
    parameter int MAX_DIM = 64
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en_a,
    input  logic                               i_wr_en_b,
    input  logic [2*$clog2(MAX_DIM)-1:0]       i_wr_addr,
    input  logic [15:0]                        i_wr_data,
    input  logic [2*$clog2(MAX_DIM)-1:0]       i_rd_addr_a,
    input  logic [2*$clog2(MAX_DIM)-1:0]       i_rd_addr_b,
    output logic [15:0]                        o_rd_data_a,
    output logic [15:0]                        o_rd_data_b
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [15:0] r_mem_a [DEPTH];
    logic [15:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem_a[i_rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_b <= r_mem_b[i_rd_addr_b];
    end

endmodule

>>> hw/rtl/bfmm_mac.sv
// bfmm_mac: multi-cycle bf16 multiply and fp32 accumulate with one shared normalize/round unit
// depends on bfmm_pkg
module bfmm_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfmm_pkg::t_mac_ctl   i_ctl,
    input  logic [15:0]          i_a,
    input  logic [15:0]          i_b,
    output logic                 o_done,
    output logic [31:0]          o_sum
);
    import bfmm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NRM  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;
    localparam logic [1:0] PH_ADD  = 2'd3;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] z;
        z = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                z = 6'(31 - i);
            end
        end
        return z;
    endfunction

    logic [1:0]         r_ph;
    logic               r_second;
    logic               r_done;
    logic               r_spec;
    logic [31:0]        r_spec_val;
    logic               r_sgn;
    logic signed [10:0] r_exp;
    logic [31:0]        r_sig;
    logic [31:0]        r_prod;
    logic [31:0]        r_sum;

    // product unpack
    logic               m_spec;
    logic [31:0]        m_val;
    logic               m_sgn;
    logic signed [10:0] m_exp;
    logic [31:0]        m_sig;

    always_comb begin
        logic       xn, yn, xi, yi, xz, yz;
        logic [7:0] ex, ey;
        logic [15:0] p;
        xn = (i_a[14:7] == 8'hFF) && (i_a[6:0] != 7'd0);
        yn = (i_b[14:7] == 8'hFF) && (i_b[6:0] != 7'd0);
        xi = (i_a[14:7] == 8'hFF) && (i_a[6:0] == 7'd0);
        yi = (i_b[14:7] == 8'hFF) && (i_b[6:0] == 7'd0);
        xz = (i_a[14:0] == 15'd0);
        yz = (i_b[14:0] == 15'd0);
        ex = (i_a[14:7] == 8'd0) ? 8'd1 : i_a[14:7];
        ey = (i_b[14:7] == 8'd0) ? 8'd1 : i_b[14:7];
        p  = {i_a[14:7] != 8'd0, i_a[6:0]} * {i_b[14:7] != 8'd0, i_b[6:0]};
        m_sgn  = i_a[15] ^ i_b[15];
        m_exp  = $signed({3'b0, ex}) + $signed({3'b0, ey}) - 11'sd253;
        m_sig  = {p, 16'd0};
        m_spec = 1'b1;
        m_val  = 32'd0;
        if (xn) begin
            m_val = {i_a, 16'd0} | F32_QUIET;
        end else if (yn) begin
            m_val = {i_b, 16'd0} | F32_QUIET;
        end else if ((xi && yz) || (xz && yi)) begin
            m_val = F32_DEF_NAN;
        end else if (xi || yi) begin
            m_val = {m_sgn, 8'hFF, 23'd0};
        end else if (xz || yz) begin
            m_val = {m_sgn, 31'd0};
        end else begin
            m_spec = 1'b0;
        end
    end

    // alignment and add of sum and product
    logic               a_spec;
    logic [31:0]        a_val;
    logic               a_sgn;
    logic signed [10:0] a_exp;
    logic [31:0]        a_sig;

    always_comb begin
        logic        sn, pn, si, pi_, sz, pz, swap, lost;
        logic [31:0] big, sml;
        logic [7:0]  eb, es, d;
        logic [26:0] bx, sx, sxs;
        logic [27:0] res;
        sn  = (r_sum[30:23] == 8'hFF) && (r_sum[22:0] != 23'd0);
        pn  = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] != 23'd0);
        si  = (r_sum[30:23] == 8'hFF) && (r_sum[22:0] == 23'd0);
        pi_ = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] == 23'd0);
        sz  = (r_sum[30:0] == 31'd0);
        pz  = (r_prod[30:0] == 31'd0);
        swap = r_prod[30:0] > r_sum[30:0];
        big  = swap ? r_prod : r_sum;
        sml  = swap ? r_sum : r_prod;
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb - es;
        bx   = {big[30:23] != 8'd0, big[22:0], 3'd0};
        sx   = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        sxs  = sx >> d;
        lost = |(sx & ~(27'h7FF_FFFF << d));
        sxs[0] = sxs[0] | lost;
        res  = (big[31] ^ sml[31]) ? ({1'b0, bx} - {1'b0, sxs}) : ({1'b0, bx} + {1'b0, sxs});
        a_sgn  = big[31];
        a_exp  = $signed({3'b0, eb}) - 11'sd126;
        a_sig  = {res, 4'd0};
        a_spec = 1'b1;
        a_val  = 32'd0;
        if (sn) begin
            a_val = r_sum | F32_QUIET;
        end else if (pn) begin
            a_val = r_prod | F32_QUIET;
        end else if (si && pi_ && (r_sum[31] != r_prod[31])) begin
            a_val = F32_DEF_NAN;
        end else if (si) begin
            a_val = r_sum;
        end else if (pi_) begin
            a_val = r_prod;
        end else if (sz && pz) begin
            a_val = {r_sum[31] & r_prod[31], 31'd0};
        end else if (res == 28'd0) begin
            a_val = 32'd0;
        end else begin
            a_spec = 1'b0;
        end
    end

    // normalize
    logic [5:0]         nrm_z;
    logic [31:0]        nrm_sig;
    logic signed [10:0] nrm_exp;

    assign nrm_z   = lzc32(r_sig);
    assign nrm_sig = r_sig << nrm_z;
    assign nrm_exp = r_exp - $signed({5'd0, nrm_z});

    // round to fp32, nearest even, with gradual underflow
    logic [31:0] rnd_val;

    always_comb begin
        logic signed [10:0] be;
        logic [5:0]         sh;
        logic [31:0]        ss;
        logic [7:0]         eb;
        logic               lost, up;
        logic [30:0]        mag;
        be = r_exp + 11'sd127;
        sh = 6'd0;
        eb = be[7:0];
        if (be <= 11'sd0) begin
            sh = (be < -11'sd30) ? 6'd32 : 6'(11'sd1 - be);
            eb = 8'd0;
        end
        ss   = r_sig >> sh;
        lost = |(r_sig & ~(32'hFFFF_FFFF << sh));
        ss[0] = ss[0] | lost;
        up   = ss[7] & ((|ss[6:0]) | ss[8]);
        mag  = {eb, ss[30:8]} + {30'd0, up};
        if (r_spec) begin
            rnd_val = r_spec_val;
        end else if (be >= 11'sd255) begin
            rnd_val = {r_sgn, 8'hFF, 23'd0};
        end else begin
            rnd_val = {r_sgn, mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= PH_IDLE;
            r_second <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_ctl.start) begin
                        r_ph     <= PH_NRM;
                        r_second <= 1'b0;
                    end
                end
                PH_NRM: begin
                    r_ph <= PH_RND;
                end
                PH_RND: begin
                    if (r_second) begin
                        r_ph   <= PH_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_ph <= PH_ADD;
                    end
                end
                PH_ADD: begin
                    r_ph     <= PH_NRM;
                    r_second <= 1'b1;
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            PH_IDLE: begin
                if (i_ctl.start) begin
                    r_spec     <= m_spec;
                    r_spec_val <= m_val;
                    r_sgn      <= m_sgn;
                    r_exp      <= m_exp;
                    r_sig      <= m_sig;
                    if (i_ctl.clear) begin
                        r_sum <= 32'd0;
                    end
                end
            end
            PH_NRM: begin
                r_sig <= nrm_sig;
                r_exp <= nrm_exp;
            end
            PH_RND: begin
                if (r_second) begin
                    r_sum <= rnd_val;
                end else begin
                    r_prod <= rnd_val;
                end
            end
            PH_ADD: begin
                r_spec     <= a_spec;
                r_spec_val <= a_val;
                r_sgn      <= a_sgn;
                r_exp      <= a_exp;
                r_sig      <= a_sig;
            end
            default: begin
                r_sig <= r_sig;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

>>> hw/rtl/bf16_matmul_two_layouts_top.sv
// bf16_matmul_two_layouts_top: bf16 matrix multiply, fp32 accumulate, two operand layouts
// depends on bfmm_pkg, bfmm_store, bfmm_mac
//
//   channel | handshake                | payload
//   in      | i_in_valid / o_in_stall  | i_in_data  (t_in)
//   out     | o_out_valid / i_out_stall| o_out_data (t_out)
//   cfg     | i_cfg_wr_en              | i_cfg_index, i_cfg_data
//
// the write of a load transaction lands in the operand memory at acceptance
// an emit transaction computes every column of the row in turn: each product term needs a
// memory read, a multiply and two passes through the shared normalize/round unit
// the output register frees the input side once the last element is loaded
// synchronous active-low reset; memories are not cleared
// a stalled output holds the sequencer before it loads the next element
module bf16_matmul_two_layouts_top #(
    parameter int MAX_DIM = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bfmm_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bfmm_pkg::t_out                o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [bfmm_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [bfmm_pkg::CFG_DW-1:0]   i_cfg_data
);
    import bfmm_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;
    localparam int CW = $clog2(MAX_DIM + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    function automatic logic [CW-1:0] clamp_dim(input logic [CFG_DW-1:0] v);
        if (v == '0) begin
            return CW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return CW'(MAX_DIM);
        end
        return CW'(v);
    endfunction

    logic              r_mode;
    logic [CFG_DW-1:0] r_inner;
    logic [CFG_DW-1:0] r_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_inner <= CFG_DW'(64);
            r_batch <= CFG_DW'(64);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LAYOUT: r_mode  <= i_cfg_data[0];
                CFG_INNER:  r_inner <= i_cfg_data;
                CFG_BATCH:  r_batch <= i_cfg_data;
                default:    r_mode  <= r_mode;
            endcase
        end
    end

    logic [CW-1:0] dim_n, dim_b, rows, cols;
    assign dim_n = clamp_dim(r_inner);
    assign dim_b = clamp_dim(r_batch);
    assign rows  = r_mode ? dim_b : dim_n;
    assign cols  = r_mode ? dim_n : dim_b;

    logic [2:0]    r_state;
    logic [5:0]    r_row;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_c;
    logic          r_out_valid;
    t_out          r_out_data;

    logic in_acc, out_free, in_range, do_wr, emit_ok;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_range   = (32'(i_in_data.row_index) < MAX_DIM)
                     && (32'(i_in_data.col_index) < MAX_DIM);
    assign do_wr      = in_acc && in_range
                     && (i_in_data.opcode == OP_WR_A || i_in_data.opcode == OP_WR_B);
    assign emit_ok    = in_acc && (i_in_data.opcode == OP_EMIT)
                     && (32'(i_in_data.row_index) < 32'(rows));

    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [15:0]   rd_a, rd_b;
    assign wr_addr = {IW'(i_in_data.row_index), IW'(i_in_data.col_index)};
    assign rd_addr_a = r_mode ? {IW'(r_k), IW'(r_c)} : {IW'(r_row), IW'(r_k)};
    assign rd_addr_b = r_mode ? {IW'(r_k), IW'(r_row)} : {IW'(r_c), IW'(r_k)};

    bfmm_store #(.MAX_DIM(MAX_DIM)) u_store (
        .i_clk       (i_clk),
        .i_wr_en_a   (do_wr && (i_in_data.opcode == OP_WR_A)),
        .i_wr_en_b   (do_wr && (i_in_data.opcode == OP_WR_B)),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_in_data.element),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    t_mac_ctl    mac_ctl;
    logic        mac_done;
    logic [31:0] mac_sum;
    assign mac_ctl.start = (r_state == S_GO);
    assign mac_ctl.clear = (r_k == '0);

    bfmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_PUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (emit_ok) begin
                        r_row   <= i_in_data.row_index;
                        r_k     <= '0;
                        r_c     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mac_done) begin
                        if (r_k == dim_n - CW'(1)) begin
                            r_state <= S_PUT;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        if (r_c == cols - CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + CW'(1);
                            r_k     <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && out_free) begin
            r_out_data.out_value <= f32_to_bf16(mac_sum);
            r_out_data.out_col   <= 6'(r_c);
            r_out_data.row_last  <= (r_c == cols - CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/bfmm_checker.sv
// bfmm_assert: port-level assertions for the bf16 matmul top level, plus its bind
// depends on bfmm_pkg and bf16_matmul_two_layouts_top
module bfmm_assert (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input bfmm_pkg::t_in                 i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input bfmm_pkg::t_out                o_out_data,
    input logic                          i_cfg_wr_en,
    input logic [bfmm_pkg::CFG_IW-1:0]   i_cfg_index,
    input logic [bfmm_pkg::CFG_DW-1:0]   i_cfg_data
);
    import bfmm_pkg::*;

    logic in_acc, out_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // reset empties the output and frees the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // after a load or an unused code is accepted, the input is free again in the next cycle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.opcode != OP_EMIT |=> !o_in_stall)
        else $error("load transaction kept the input stalled");

    // mid-row element means the row is still being computed
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_out_data.row_last |-> o_in_stall)
        else $error("input freed before row finished");

endmodule

bind bf16_matmul_two_layouts_top bfmm_assert u_bfmm_assert (.*);

>>> test/bfmm_checker.sv
// bfmm_checker: watches the in, out and cfg channels of the bf16 matmul block and predicts each row
// keeps its own operand stores and fp32 arithmetic; depends on bfmm_pkg only
`timescale 1ns / 100ps
module bfmm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  bfmm_pkg::t_in               i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  bfmm_pkg::t_out              i_out_data,
    input  logic                        i_cfg_wr_en,
    input  logic [bfmm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [bfmm_pkg::CFG_DW-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);
    import bfmm_pkg::*;

    localparam int DIM = 64;
    localparam logic [31:0] F32_INVALID = 32'hFFC0_0000;

    logic [15:0] op_a [DIM*DIM];
    logic [15:0] op_b [DIM*DIM];
    logic        layout;
    logic [6:0]  inner_reg;
    logic [6:0]  batch_reg;
    t_out        row_q[$];
    int          fails;
    int          results;

    function automatic int clamp_size(logic [6:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic bit is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == 0;
    endfunction

    function automatic real f32_as_real(logic [31:0] f);
        logic [10:0] dexp;
        logic [51:0] dman;
        logic [63:0] sh;
        int          lead;
        dexp = 0;
        dman = 0;
        if (f[30:23] == 8'hFF) begin
            dexp = 11'h7FF;
        end else if (f[30:23] != 0) begin
            dexp = 11'(int'(f[30:23]) + 896);
            dman = {f[22:0], 29'b0};
        end else if (f[22:0] != 0) begin
            lead = 0;
            for (int i = 0; i < 23; i++) if (f[i]) lead = i;
            dexp = 11'(lead - 149 + 1023);
            sh = 64'(f[22:0]) << (52 - lead);
            dman = sh[51:0];
        end
        return $bitstoreal({f[31], dexp, dman});
    endfunction

    function automatic logic [63:0] shift_rne(logic [63:0] m, int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        return q;
    endfunction

    // round a double to fp32, nearest even, subnormals kept
    function automatic logic [31:0] real_as_f32(real r);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] q;
        logic [31:0] res;
        int          e;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'b0};
        if (d[62:52] == 0) return {d[63], 31'b0};
        e = int'(d[62:52]) - 1023;
        if (e > 127) return {d[63], 8'hFF, 23'b0};
        m = {11'b1, d[51:0]};
        if (e >= -126) begin
            q = shift_rne(m, 29);
            res = 32'((e + 126) << 23) + q[31:0];
            if (res >= 32'h7F80_0000) return {d[63], 8'hFF, 23'b0};
        end else if (29 - 126 - e >= 64) begin
            res = 0;
        end else begin
            q = shift_rne(m, 29 - 126 - e);
            res = q[31:0];
        end
        return {d[63], res[30:0]};
    endfunction

    function automatic logic [31:0] bf16_product(logic [15:0] x, logic [15:0] y);
        logic [31:0] fx;
        logic [31:0] fy;
        fx = {x, 16'b0};
        fy = {y, 16'b0};
        if (is_nan(fx)) return fx | F32_QUIET;
        if (is_nan(fy)) return fy | F32_QUIET;
        if ((is_inf(fx) && fy[30:0] == 0) || (is_inf(fy) && fx[30:0] == 0)) return F32_INVALID;
        return real_as_f32(f32_as_real(fx) * f32_as_real(fy));
    endfunction

    function automatic logic [31:0] f32_sum(logic [31:0] s, logic [31:0] p);
        if (is_nan(s)) return s | F32_QUIET;
        if (is_nan(p)) return p | F32_QUIET;
        if (is_inf(s) && is_inf(p) && s[31] != p[31]) return F32_INVALID;
        return real_as_f32(f32_as_real(s) + f32_as_real(p));
    endfunction

    function automatic logic [15:0] narrow_bf16(logic [31:0] f);
        logic [31:0] t;
        if (is_nan(f)) return f[31:16] | 16'h0040;
        t = f + 32'h7FFF + 32'(f[16]);
        return t[31:16];
    endfunction

    task automatic predict_row(input t_in t);
        int          n;
        int          nb;
        int          rows;
        int          cols;
        logic [31:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        t_out        r;
        n = clamp_size(inner_reg);
        nb = clamp_size(batch_reg);
        rows = layout ? nb : n;
        cols = layout ? n : nb;
        if (t.opcode == OP_WR_A) begin
            op_a[int'(t.row_index) * DIM + int'(t.col_index)] = t.element;
        end else if (t.opcode == OP_WR_B) begin
            op_b[int'(t.row_index) * DIM + int'(t.col_index)] = t.element;
        end else if (t.opcode == OP_EMIT && int'(t.row_index) < rows) begin
            for (int c = 0; c < cols; c++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    if (!layout) begin
                        x = op_a[int'(t.row_index) * DIM + k];
                        y = op_b[c * DIM + k];
                    end else begin
                        x = op_a[k * DIM + c];
                        y = op_b[k * DIM + int'(t.row_index)];
                    end
                    acc = f32_sum(acc, bf16_product(x, y));
                end
                r.out_value = narrow_bf16(acc);
                r.out_col = 6'(c);
                r.row_last = (c + 1 == cols);
                row_q.push_back(r);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DIM*DIM; i++) begin
            op_a[i] = 0;
            op_b[i] = 0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            row_q.delete();
            layout <= 1'b0;
            inner_reg <= 7'd64;
            batch_reg <= 7'd64;
            fails = 0;
            results = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LAYOUT: layout <= i_cfg_data[0];
                    CFG_INNER:  inner_reg <= i_cfg_data;
                    CFG_BATCH:  batch_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (row_q.size() == 0) begin
                    $error("result with nothing expected: %h", i_out_data);
                    fails++;
                end else begin
                    want = row_q.pop_front();
                    if (want.out_value !== i_out_data.out_value) begin
                        $error("out_value mismatch: expected %h, got %h",
                               want.out_value, i_out_data.out_value);
                        fails++;
                    end
                    if (want.out_col !== i_out_data.out_col) begin
                        $error("out_col mismatch: expected %0d, got %0d",
                               want.out_col, i_out_data.out_col);
                        fails++;
                    end
                    if (want.row_last !== i_out_data.row_last) begin
                        $error("row_last mismatch: expected %b, got %b",
                               want.row_last, i_out_data.row_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_row(i_in_data);
        end
        o_pending <= row_q.size();
        o_fail_count <= fails + ((!i_rst_n) ? 0 : 0);
        o_result_count <= results;
    end

endmodule

>>> test/bf16_matmul_two_layouts_top_tb.sv
// bf16_matmul_two_layouts_top_tb: stimulus and verdict for the bf16 matmul block
// depends on bfmm_pkg, bf16_matmul_two_layouts_top and bfmm_checker
`timescale 1ns / 100ps
module bf16_matmul_two_layouts_top_tb;
    import bfmm_pkg::*;

    localparam int DIM = 64;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in               in_data;
    logic              out_valid;
    logic              out_stall;
    t_out              out_data;
    logic              cfg_wr_en;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                result_count;

    int send_idle;
    int recv_idle;
    int items;
    int emits;
    int cur_mode;
    int cur_n;
    int cur_b;
    bit wr_a [DIM*DIM];
    bit wr_b [DIM*DIM];

    bf16_matmul_two_layouts_top #(.MAX_DIM(DIM)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bfmm_checker u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    function automatic int clamp_size(int v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return v;
    endfunction

    function automatic logic [15:0] rand_bf16();
        logic [15:0] picks [8];
        int          r;
        picks = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC1, 16'h0001, 16'h7F7F, 16'h0080};
        r = $urandom_range(9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return picks[$urandom_range(7)];
        return {1'($urandom), 8'($urandom_range(120, 134)), 7'($urandom)};
    endfunction

    // one transaction on the in channel; called right after a rising edge
    task automatic send_txn(input t_in t, input bit counted);
        int gap;
        if (items < 130) begin
            send_idle = 17;
            recv_idle = 65;
        end else if (items < 260) begin
            send_idle = 65;
            recv_idle = 17;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        if (counted) items++;
    endtask

    task automatic load(input logic [1:0] op, input int row, input int col, input logic [15:0] v);
        t_in t;
        t.opcode = op;
        t.row_index = 6'(row);
        t.col_index = 6'(col);
        t.element = v;
        send_txn(t, 1'b1);
        if (op == OP_WR_A) wr_a[row * DIM + col] = 1'b1;
        else wr_b[row * DIM + col] = 1'b1;
    endtask

    // fills any operand entry the row would read before it is emitted
    task automatic emit_row(input int row);
        t_in t;
        int  rows;
        int  cols;
        rows = cur_mode ? cur_b : cur_n;
        cols = cur_mode ? cur_n : cur_b;
        if (row < rows) begin
            for (int k = 0; k < cur_n; k++) begin
                if (cur_mode == 0) begin
                    if (!wr_a[row * DIM + k]) load(OP_WR_A, row, k, rand_bf16());
                    for (int c = 0; c < cols; c++)
                        if (!wr_b[c * DIM + k]) load(OP_WR_B, c, k, rand_bf16());
                end else begin
                    if (!wr_b[k * DIM + row]) load(OP_WR_B, k, row, rand_bf16());
                    for (int c = 0; c < cols; c++)
                        if (!wr_a[k * DIM + c]) load(OP_WR_A, k, c, rand_bf16());
                end
            end
            emits++;
        end
        t.opcode = OP_EMIT;
        t.row_index = 6'(row);
        t.col_index = 6'($urandom);
        t.element = 16'($urandom);
        send_txn(t, row < rows);
    endtask

    task automatic send_unused();
        t_in t;
        t = t_in'(30'($urandom));
        t.opcode = OP_UNUSED;
        send_txn(t, 1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DW'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_phase(input int mode, input int inner_v, input int batch_v);
        drain();
        write_reg(CFG_LAYOUT, mode);
        write_reg(CFG_INNER, inner_v);
        write_reg(CFG_BATCH, batch_v);
        @(posedge clk);
        cur_mode = mode;
        cur_n = clamp_size(inner_v);
        cur_b = clamp_size(batch_v);
    endtask

    task automatic run_phase(input int quota);
        int start;
        int r;
        int rows;
        logic [1:0] op;
        start = items;
        rows = cur_mode ? cur_b : cur_n;
        while (items - start < quota) begin
            r = $urandom_range(99);
            op = $urandom_range(1) ? OP_WR_B : OP_WR_A;
            if (r < 45) begin
                emit_row($urandom_range(rows - 1));
            end else if (r < 80) begin
                if (op == OP_WR_A)
                    load(op, $urandom_range(cur_n - 1), $urandom_range(cur_n - 1), rand_bf16());
                else if (cur_mode == 0)
                    load(op, $urandom_range(cur_b - 1), $urandom_range(cur_n - 1), rand_bf16());
                else
                    load(op, $urandom_range(cur_n - 1), $urandom_range(cur_b - 1), rand_bf16());
            end else if (r < 88) begin
                load(op, $urandom_range(63), $urandom_range(63), 16'($urandom));
            end else if (r < 94 && rows < DIM) begin
                emit_row($urandom_range(rows, 63));
            end else begin
                send_unused();
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 17;
        recv_idle = 65;
        items = 0;
        emits = 0;
        cur_mode = 0;
        cur_n = DIM;
        cur_b = DIM;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // overflow to infinity, inf minus inf, nan input, subnormal, field extremes
        set_phase(0, 2, 2);
        load(OP_WR_A, 0, 0, 16'h7F7F);
        load(OP_WR_A, 0, 1, 16'h7F7F);
        load(OP_WR_B, 0, 0, 16'h7F7F);
        load(OP_WR_B, 0, 1, 16'h7F7F);
        load(OP_WR_B, 1, 0, 16'hFF80);
        load(OP_WR_B, 1, 1, 16'h7F80);
        load(OP_WR_A, 1, 0, 16'h7FC1);
        load(OP_WR_A, 1, 1, 16'h0001);
        emit_row(0);
        emit_row(1);
        emit_row(2);
        emit_row(63);
        send_unused();
        load(OP_WR_A, 63, 63, 16'hFFFF);
        load(OP_WR_B, 63, 63, 16'h0000);
        load(OP_WR_A, 0, 0, 16'h8000);
        emit_row(0);

        set_phase(0, 0, 127);
        run_phase(30);
        set_phase(1, 2, 100);
        run_phase(30);
        set_phase(0, 64, 1);
        run_phase(25);
        set_phase(1, 1, 64);
        run_phase(20);
        for (int p = 0; p < 5; p++) begin
            set_phase($urandom_range(1), $urandom_range(1, 8), $urandom_range(1, 8));
            run_phase(20);
        end

        drain();
        repeat (60) @(posedge clk);
        $display("run covered %0d transactions, %0d row emits, %0d results checked",
                 items, emits, result_count);
        $display("both layouts, clamped and extreme sizes, special values, three idle regimes");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
